>>> rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helpers of the UTF-8 to UTF-16LE converter.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // width of the internal saturating unit counter
    localparam int COUNT_WIDTH = 16;
    // width of the reported unit count
    localparam int UNIT_COUNT_W = 16;
    localparam int WIDE_W = COUNT_WIDTH + UNIT_COUNT_W;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    // kinds of result item
    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_TERM = 2'd1,
        KIND_OK   = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [15:0]              code_unit;
        logic [UNIT_COUNT_W-1:0]  unit_count;
        logic                     last;
    } result_t;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    // clamp the internal count to the reported width
    function automatic logic [UNIT_COUNT_W-1:0] count_out(
        input logic [COUNT_WIDTH-1:0] cnt
    );
        logic [WIDE_W-1:0] wide;
        logic [WIDE_W-1:0] lim;
        begin
            wide = WIDE_W'(cnt);
            lim  = WIDE_W'({UNIT_COUNT_W{1'b1}});
            if (wide > lim)
            begin
                count_out = {UNIT_COUNT_W{1'b1}};
            end
            else
            begin
                count_out = wide[UNIT_COUNT_W-1:0];
            end
        end
    endfunction

endpackage

>>> rtl/u8u16_byte_if.sv
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Input channel: one UTF-8 byte per item.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

>>> rtl/u8u16_result_if.sv
// ----------------------------------------------------------------------------
// u8u16_result_if
// Output channel: code units, terminator and end results.
// ----------------------------------------------------------------------------
interface u8u16_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic        last;

    modport source (output valid, output kind, output code_unit, output unit_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input code_unit, input unit_count,
                    input last, output ready);
endinterface

>>> rtl/u8u16_cfg_if.sv
// ----------------------------------------------------------------------------
// u8u16_cfg_if
// Configuration write channel for the append_terminator register.
// ----------------------------------------------------------------------------
interface u8u16_cfg_if;
    logic valid;
    logic ready;
    logic append_terminator;

    modport source (output valid, output append_terminator, input ready);
    modport sink   (input valid, input append_terminator, output ready);
endinterface

>>> rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Input register, UTF-8 decode state and result generation for one byte.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    u8u16_byte_if.sink              byte_chan,
    u8u16_cfg_if.sink               cfg,
    input  logic                    room,
    output u8u16_pkg::push_t        push
);

    logic [7:0]                         byte_reg;
    logic                               byte_valid_reg;
    logic                               term_reg;
    logic [1:0]                         pending_reg, pending_next;
    logic [9:0]                         partial_reg, partial_next;
    logic [u8u16_pkg::COUNT_WIDTH-1:0]  units_reg, units_next;
    logic                               error_reg, error_next;
    logic                               consume;
    logic                               emit;
    logic [15:0]                        emit_unit;
    logic                               fail;
    u8u16_pkg::result_t                 end_res;

    assign consume         = byte_valid_reg & room;
    assign byte_chan.ready = ~byte_valid_reg | consume;
    assign cfg.ready       = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            byte_valid_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_chan.valid && byte_chan.ready)
        begin
            byte_reg <= byte_chan.text_byte;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            term_reg <= cfg.append_terminator;
        end
    end

    // decode of the held byte
    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        units_next   = units_reg;
        error_next   = error_reg;
        emit         = 1'b0;
        emit_unit    = 16'h0000;
        fail         = 1'b0;
        end_res      = '0;
        push         = '0;

        if (byte_reg == 8'h00)
        begin
            fail              = error_reg | (pending_reg != 2'd0);
            if (fail)
            begin
                end_res.kind = u8u16_pkg::KIND_ERR;
            end
            else
            begin
                end_res.kind = u8u16_pkg::KIND_OK;
            end
            end_res.code_unit = 16'h0000;
            end_res.unit_count = u8u16_pkg::count_out(units_reg);
            end_res.last      = 1'b1;
            if (!fail && term_reg)
            begin
                push.num              = 2'd2;
                push.first.kind       = u8u16_pkg::KIND_TERM;
                push.first.code_unit  = 16'h0000;
                push.first.unit_count = u8u16_pkg::count_out(units_reg);
                push.first.last       = 1'b0;
                push.second           = end_res;
            end
            else
            begin
                push.num   = 2'd1;
                push.first = end_res;
            end
            pending_next = 2'd0;
            partial_next = '0;
            units_next   = '0;
            error_next   = 1'b0;
        end
        else if (!error_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                // lead byte
                if (!byte_reg[7])
                begin
                    emit      = 1'b1;
                    emit_unit = {8'h00, byte_reg};
                end
                else if (byte_reg[7:5] == 3'b110)
                begin
                    pending_next = 2'd1;
                    partial_next = {5'b0, byte_reg[4:0]};
                end
                else if (byte_reg[7:4] == 4'b1110)
                begin
                    pending_next = 2'd2;
                    partial_next = {6'b0, byte_reg[3:0]};
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (byte_reg[7:6] != 2'b10)
            begin
                fail = 1'b1;
            end
            else if (pending_reg == 2'd1)
            begin
                emit         = 1'b1;
                emit_unit    = {partial_reg, byte_reg[5:0]};
                pending_next = 2'd0;
                partial_next = '0;
            end
            else
            begin
                partial_next = {partial_reg[3:0], byte_reg[5:0]};
                pending_next = pending_reg - 2'd1;
            end

            if (fail)
            begin
                error_next   = 1'b1;
                pending_next = 2'd0;
                partial_next = '0;
            end

            // saturating count and unit result
            if (emit)
            begin
                if (units_reg != {u8u16_pkg::COUNT_WIDTH{1'b1}})
                begin
                    units_next = units_reg + 1'b1;
                end
                push.num              = 2'd1;
                push.first.kind       = u8u16_pkg::KIND_UNIT;
                push.first.code_unit  = emit_unit;
                push.first.unit_count = u8u16_pkg::count_out(units_next);
                push.first.last       = 1'b0;
            end
        end

        if (!consume)
        begin
            push.num = 2'd0;
        end
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            units_reg   <= '0;
            error_reg   <= 1'b0;
        end
        else if (consume)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            units_reg   <= units_next;
            error_reg   <= error_next;
        end
    end

endmodule

>>> rtl/u8u16_fifo.sv
// ----------------------------------------------------------------------------
// u8u16_fifo
// Small result queue taking up to two items per cycle, one out per cycle when ready.
// ----------------------------------------------------------------------------
module u8u16_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  u8u16_pkg::push_t    push,
    output logic                room,
    u8u16_result_if.source      unit_chan
);

    u8u16_pkg::result_t                 mem_reg [u8u16_pkg::FIFO_DEPTH];
    logic [u8u16_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [u8u16_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [u8u16_pkg::FIFO_CW-1:0]      count_reg, count_next;
    logic                               pop;
    u8u16_pkg::result_t                 head;

    // room for two items regardless of the read side
    assign room = count_reg <= u8u16_pkg::FIFO_CW'(u8u16_pkg::FIFO_DEPTH - 2);
    assign pop  = unit_chan.valid & unit_chan.ready;

    assign wr_ptr_next = wr_ptr_reg + u8u16_pkg::FIFO_AW'(push.num);
    assign count_next  = count_reg + u8u16_pkg::FIFO_CW'(push.num)
                         - u8u16_pkg::FIFO_CW'(pop);

    // storage
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // head of queue drives the output channel
    assign head                 = mem_reg[rd_ptr_reg];
    assign unit_chan.valid      = count_reg != '0;
    assign unit_chan.kind       = head.kind;
    assign unit_chan.code_unit  = head.code_unit;
    assign unit_chan.unit_count = head.unit_count;
    assign unit_chan.last       = head.last;

endmodule

>>> rtl/utf8_to_utf16le_converter.sv
// Path: an accepted byte is held in the input register, then pushed into the output
// queue once the queue has room; its first result is offered from the queue head.
// Throughput: one byte per cycle while the queue has room for two; a string end with
// terminator yields two results, so the output queue (four entries) absorbs the extra item.
// Sustained rate: one result per cycle while ready, set by the single-entry read.
// Reset (rst_n low, asynchronous) clears decode state, the terminator option,
// the input register and the output queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// utf8_to_utf16le_converter
// UTF-8 byte stream to UTF-16LE code units (basic multilingual plane).
// ----------------------------------------------------------------------------
module utf8_to_utf16le_converter (
    input  logic            clk,
    input  logic            rst_n,
    u8u16_byte_if.sink      byte_chan,
    u8u16_result_if.source  unit_chan,
    u8u16_cfg_if.sink       cfg
);

    u8u16_pkg::push_t push;
    logic             room;

    // byte decode
    u8u16_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .cfg       (cfg),
        .room      (room),
        .push      (push)
    );

    // result queue
    u8u16_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .unit_chan (unit_chan)
    );

endmodule

>>> rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the converter output stream.
// ----------------------------------------------------------------------------
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [15:0] out_code_unit,
    input logic [15:0] out_unit_count,
    input logic        out_last
);

    // stalled item stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_code_unit))
        else $error("output item changed while stalled");

    // last marks exactly the end results
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_kind == u8u16_pkg::KIND_OK
            || out_kind == u8u16_pkg::KIND_ERR)))
        else $error("last flag does not match kind");

    // only code unit items carry data
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != u8u16_pkg::KIND_UNIT |-> out_code_unit == 16'h0000)
        else $error("non-unit item carries data");

    // a code unit is always counted
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == u8u16_pkg::KIND_UNIT |-> out_unit_count != 16'h0000)
        else $error("code unit with zero count");

endmodule

bind utf8_to_utf16le_converter u8u16_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (unit_chan.valid),
    .out_ready      (unit_chan.ready),
    .out_kind       (unit_chan.kind),
    .out_code_unit  (unit_chan.code_unit),
    .out_unit_count (unit_chan.unit_count),
    .out_last       (unit_chan.last)
);
